// ===== rtl/wtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared widths, register indexes and sideband types of the world-to-screen
// projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  // Field widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned LIN_W  = 3 * COEF_W;
  localparam int unsigned OFF_W  = 32;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned COEF_FRAC = 12;

  // Internal widths: clip accumulator, product, numerator and magnitudes
  localparam int unsigned PROD_W = COEF_W + POS_W;
  localparam int unsigned ACC_W  = 50;
  localparam int unsigned NUM_W  = 66;
  localparam int unsigned MAG_W  = NUM_W;

  // Divider: quotient bits resolved one per stage
  localparam int unsigned Q_W        = 16;
  localparam int unsigned DIV_STAGES = Q_W + 1;

  // Pipeline layout: products, sums, scale, magnitudes, divider, output
  localparam int unsigned PIPE_DEPTH = 4 + DIV_STAGES + 1;
  localparam int unsigned SIDE_DEPTH = DIV_STAGES + 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROW_X_LIN = 3'd0,
    REG_ROW_X_OFF = 3'd1,
    REG_ROW_Y_LIN = 3'd2,
    REG_ROW_Y_OFF = 3'd3,
    REG_ROW_W_LIN = 3'd4,
    REG_ROW_W_OFF = 3'd5,
    REG_SCR_WIDTH = 3'd6,
    REG_SCR_HEIGHT = 3'd7
  } reg_idx_e;

  // Values that travel beside the divider
  typedef struct packed {
    logic                      fault;
    logic                      cx_nonneg;
    logic                      cy_nonneg;
    logic signed [DEPTH_W-1:0] depth;
  } side_t;

endpackage

// ===== rtl/world_to_screen_projection_top.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Projects world points through a configured view matrix to pixel positions.
// ----------------------------------------------------------------------------
// Takes one world point per cycle while stall_o is low and returns its screen
// position, clip w and a zero-w flag. The two perspective dividers resolve
// their 16-bit quotients one bit per stage after the matrix products, row
// sums and pixel scaling. The whole pipeline holds while a finished beat is
// stalled; no beat is dropped or repeated. Write the configuration only
// while no beat is in flight.
module world_to_screen_projection_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [wtsp_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [wtsp_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [wtsp_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [wtsp_pkg::POS_W-1:0]   pos_z_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [wtsp_pkg::PIX_W-1:0]   screen_x_o,
  output logic signed [wtsp_pkg::PIX_W-1:0]   screen_y_o,
  output logic signed [wtsp_pkg::DEPTH_W-1:0] depth_w_o,
  output logic                                div_fault_o
);

  localparam int unsigned PW  = wtsp_pkg::PROD_W;
  localparam int unsigned AW  = wtsp_pkg::ACC_W;
  localparam int unsigned NW  = wtsp_pkg::NUM_W;
  localparam int unsigned QW  = wtsp_pkg::Q_W;
  localparam int unsigned CW  = wtsp_pkg::COEF_W;
  localparam int unsigned SW  = wtsp_pkg::SIZE_W;
  localparam int unsigned DW  = wtsp_pkg::DEPTH_W;
  localparam int unsigned XW  = wtsp_pkg::PIX_W;
  localparam int unsigned ND  = wtsp_pkg::PIPE_DEPTH;
  localparam int unsigned NSD = wtsp_pkg::SIDE_DEPTH;
  localparam logic signed [XW-1:0] PixMax = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] PixMin = {1'b1, {(XW-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [wtsp_pkg::LIN_W-1:0]  lin_q [3];
  logic [wtsp_pkg::OFF_W-1:0]  off_q [3];
  logic [SW-1:0]               width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q[0] <= '0;
      lin_q[1] <= '0;
      lin_q[2] <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= 32'd65536;
      width_q  <= 13'd1920;
      height_q <= 13'd1080;
    end else if (cfg_we_i) begin
      unique case (wtsp_pkg::reg_idx_e'(cfg_idx_i))
        wtsp_pkg::REG_ROW_X_LIN:  lin_q[0] <= cfg_data_i;
        wtsp_pkg::REG_ROW_X_OFF:  off_q[0] <= cfg_data_i[31:0];
        wtsp_pkg::REG_ROW_Y_LIN:  lin_q[1] <= cfg_data_i;
        wtsp_pkg::REG_ROW_Y_OFF:  off_q[1] <= cfg_data_i[31:0];
        wtsp_pkg::REG_ROW_W_LIN:  lin_q[2] <= cfg_data_i;
        wtsp_pkg::REG_ROW_W_OFF:  off_q[2] <= cfg_data_i[31:0];
        wtsp_pkg::REG_SCR_WIDTH:  width_q  <= cfg_data_i[SW-1:0];
        wtsp_pkg::REG_SCR_HEIGHT: height_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic          en;
  logic [ND-1:0] vld_q;

  assign en      = !vld_q[ND-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[ND-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ND-2:0], valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: nine coefficient products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [wtsp_pkg::POS_W-1:0] pos [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[r][k] = $signed(lin_q[r][k*CW +: CW]) * pos[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: row sums plus offsets, exact clip x, y, w
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] acc_d [3];
  logic signed [AW-1:0] acc_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = AW'(prod_q[r][0]) + AW'(prod_q[r][1]) + AW'(prod_q[r][2])
               + AW'($signed({off_q[r], {wtsp_pkg::COEF_FRAC{1'b0}}}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= acc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale to pixel numerators, depth and zero-w flag
  // --------------------------------------------------------------------------
  logic signed [AW:0]    sum_x, dif_y;
  logic signed [SW:0]    wd_s, ht_s;
  logic signed [NW-1:0]  nx_d, ny_d, den_d, nx_q, ny_q, den_q;
  logic signed [AW-wtsp_pkg::COEF_FRAC-1:0] dsh;
  wtsp_pkg::side_t       side_d;
  wtsp_pkg::side_t       side_q [NSD];

  assign sum_x = (AW+1)'(acc_q[2]) + (AW+1)'(acc_q[0]);
  assign dif_y = (AW+1)'(acc_q[2]) - (AW+1)'(acc_q[1]);
  assign wd_s  = $signed({1'b0, width_q});
  assign ht_s  = $signed({1'b0, height_q});
  assign nx_d  = NW'(wd_s * sum_x) + NW'(acc_q[2]);
  assign ny_d  = NW'(ht_s * dif_y) - NW'(acc_q[2]);
  assign den_d = NW'($signed({acc_q[2], 1'b0}));
  assign dsh   = acc_q[2][AW-1:wtsp_pkg::COEF_FRAC];

  // Floor of w in Q16.16, saturated to 32 bits; zero when w is zero
  always_comb begin
    side_d.fault     = (acc_q[2] == '0);
    side_d.cx_nonneg = !acc_q[0][AW-1];
    side_d.cy_nonneg = !acc_q[1][AW-1];
    if (dsh > $signed((AW-wtsp_pkg::COEF_FRAC)'({1'b0, {(DW-1){1'b1}}}))) begin
      side_d.depth = {1'b0, {(DW-1){1'b1}}};
    end else if (dsh < $signed(-(AW-wtsp_pkg::COEF_FRAC)'({1'b1, {(DW-1){1'b0}}}))) begin
      side_d.depth = {1'b1, {(DW-1){1'b0}}};
    end else begin
      side_d.depth = dsh[DW-1:0];
    end
    if (side_d.fault) begin
      side_d.depth = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      den_q     <= den_d;
      side_q[0] <= side_d;
      for (int i = 1; i < NSD; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: split numerators and divisor into signs and magnitudes
  // --------------------------------------------------------------------------
  logic [NW-1:0] mx_q, my_q, md_q;
  logic          negx_q, negy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      my_q   <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      md_q   <= den_q[NW-1] ? NW'(-den_q) : NW'(den_q);
      negx_q <= nx_q[NW-1] ^ den_q[NW-1];
      negy_q <= ny_q[NW-1] ^ den_q[NW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Dividers for x and y
  // --------------------------------------------------------------------------
  logic [QW-1:0] qx, qy;
  logic          rx, ry, ox, oy, gx, gy;

  wtsp_div u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (mx_q),
    .den_i    (md_q),
    .neg_i    (negx_q),
    .quot_o   (qx),
    .rem_nz_o (rx),
    .ovf_o    (ox),
    .neg_o    (gx)
  );

  wtsp_div u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (my_q),
    .den_i    (md_q),
    .neg_i    (negy_q),
    .quot_o   (qy),
    .rem_nz_o (ry),
    .ovf_o    (oy),
    .neg_o    (gy)
  );

  // Floor the signed quotient and clamp to the pixel range
  function automatic logic signed [XW-1:0] pix_clamp(
    input logic [QW-1:0] q,
    input logic          rnz,
    input logic          ovf,
    input logic          neg
  );
    logic [QW:0] m;
    logic signed [XW-1:0] res;
    m = {1'b0, q} + (QW+1)'(rnz);
    if (ovf) begin
      res = neg ? PixMin : PixMax;
    end else if (!neg) begin
      res = q[QW-1] ? PixMax : XW'(q);
    end else if (m > (QW+1)'({1'b1, {(XW-1){1'b0}}})) begin
      res = PixMin;
    end else begin
      res = XW'(-m);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  wtsp_pkg::side_t sd;
  assign sd = side_q[NSD-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_fault_o <= sd.fault;
      depth_w_o   <= sd.depth;
      if (sd.fault) begin
        screen_x_o <= sd.cx_nonneg ? PixMax : PixMin;
        screen_y_o <= sd.cy_nonneg ? PixMin : PixMax;
      end else begin
        screen_x_o <= pix_clamp(qx, rx, ox, gx);
        screen_y_o <= pix_clamp(qy, ry, oy, gy);
      end
    end
  end

`ifndef SYNTHESIS
  // A zero w always reports zero depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_fault_o) |-> (depth_w_o == '0))
    else $error("zero-w beat with nonzero depth");

  // A zero w pins both screen coordinates to a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_fault_o) |->
      ((screen_x_o == PixMax || screen_x_o == PixMin) &&
       (screen_y_o == PixMax || screen_y_o == PixMin)))
    else $error("zero-w beat off the pixel rails");

  // Input stalls exactly when a finished beat is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("input stall out of step with output");
`endif

endmodule

// ===== rtl/wtsp_div.sv =====
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined restoring divider on magnitudes: flags a quotient of 2^16 or
// more, otherwise resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [wtsp_pkg::MAG_W-1:0]   num_i,
  input  logic [wtsp_pkg::MAG_W-1:0]   den_i,
  input  logic                         neg_i,
  output logic [wtsp_pkg::Q_W-1:0]     quot_o,
  output logic                         rem_nz_o,
  output logic                         ovf_o,
  output logic                         neg_o
);

  localparam int unsigned MW = wtsp_pkg::MAG_W;
  localparam int unsigned QW = wtsp_pkg::Q_W;
  localparam int unsigned NS = wtsp_pkg::DIV_STAGES;

  logic [MW-1:0] rem_q [NS];
  logic [MW-1:0] den_q [NS];
  logic [QW-1:0] quot_q [NS];
  logic          ovf_q [NS];
  logic          neg_q [NS];

  // Stage 0: check whether the quotient overflows 16 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= ({{QW{1'b0}}, num_i} >= {den_i, {QW{1'b0}}});
      neg_q[0]  <= neg_i;
    end
  end

  // Stages 1..16: subtract the shifted divisor where it fits
  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam int unsigned SH = QW - j;
    logic [MW+QW-1:0] trial;
    logic             fits;

    assign trial = {{QW{1'b0}}, den_q[j-1]} << SH;
    assign fits  = ({{QW{1'b0}}, rem_q[j-1]} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fits ? (rem_q[j-1] - trial[MW-1:0]) : rem_q[j-1];
        quot_q[j] <= quot_q[j-1] | (fits ? (QW'(1) << SH) : '0);
        den_q[j]  <= den_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        neg_q[j]  <= neg_q[j-1];
      end
    end
  end

  assign quot_o   = quot_q[NS-1];
  assign rem_nz_o = (rem_q[NS-1] != '0);
  assign ovf_o    = ovf_q[NS-1];
  assign neg_o    = neg_q[NS-1];

endmodule

// ===== test/world_to_screen_projection_top_tb.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection_top_tb
// Drives world points through the projection pipeline under several view
// matrix and screen size settings, predicts each screen position, depth and
// zero-w flag with exact integer math, and checks every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module world_to_screen_projection_top_tb;

  typedef struct {
    logic signed [wtsp_pkg::POS_W-1:0] px;
    logic signed [wtsp_pkg::POS_W-1:0] py;
    logic signed [wtsp_pkg::POS_W-1:0] pz;
  } point_t;

  typedef struct {
    logic signed [wtsp_pkg::PIX_W-1:0]   sx;
    logic signed [wtsp_pkg::PIX_W-1:0]   sy;
    logic signed [wtsp_pkg::DEPTH_W-1:0] dw;
    logic                                fault;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [wtsp_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [wtsp_pkg::POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [wtsp_pkg::PIX_W-1:0] screen_x_o, screen_y_o;
  logic signed [wtsp_pkg::DEPTH_W-1:0] depth_w_o;
  logic div_fault_o;

  world_to_screen_projection_top u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the view matrix and screen size
  logic [wtsp_pkg::LIN_W-1:0] lin_q [3];
  logic signed [wtsp_pkg::OFF_W-1:0] off_q [3];
  logic [wtsp_pkg::SIZE_W-1:0] width_q, height_q;

  point_t point_q[$];
  pixel_t pixel_q[$];
  int errors = 0;
  int n_beats = 0;
  int n_faults = 0;
  bit hold_off = 1'b0;
  bit send_pause = 1'b0;

  function automatic logic signed [63:0] floor_div(logic signed [127:0] a,
                                                   logic signed [127:0] b);
    logic signed [127:0] q, r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((r < 0) != (b < 0))) q = q - 1;
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] clip_row(int r, point_t p);
    logic signed [63:0] acc;
    acc = $signed(off_q[r]) * 64'sd4096;
    acc += $signed(lin_q[r][15:0]) * $signed(p.px);
    acc += $signed(lin_q[r][31:16]) * $signed(p.py);
    acc += $signed(lin_q[r][47:32]) * $signed(p.pz);
    return acc;
  endfunction

  function automatic pixel_t project(point_t p);
    pixel_t res;
    logic signed [63:0] cx, cy, cw, d;
    logic signed [127:0] wd, ht;
    cx = clip_row(0, p);
    cy = clip_row(1, p);
    cw = clip_row(2, p);
    wd = {115'd0, width_q};
    ht = {115'd0, height_q};
    if (cw == 0) begin
      res.fault = 1'b1;
      res.dw = '0;
      res.sx = (cx >= 0) ? 16'sh7fff : 16'sh8000;
      res.sy = (cy >= 0) ? 16'sh8000 : 16'sh7fff;
    end else begin
      res.fault = 1'b0;
      d = cw >>> 12;
      if (d > 64'sh7fffffff) d = 64'sh7fffffff;
      if (d < -64'sh80000000) d = -64'sh80000000;
      res.dw = d[31:0];
      res.sx = wtsp_pkg::PIX_W'(floor_div(wd * (cw + cx) + cw, 2 * cw));
      res.sy = wtsp_pkg::PIX_W'(floor_div(ht * (cw - cy) - cw, 2 * cw));
    end
    return res;
  endfunction

  task automatic write_reg(wtsp_pkg::reg_idx_e idx, logic [wtsp_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      wtsp_pkg::REG_ROW_X_LIN: lin_q[0] = data;
      wtsp_pkg::REG_ROW_Y_LIN: lin_q[1] = data;
      wtsp_pkg::REG_ROW_W_LIN: lin_q[2] = data;
      wtsp_pkg::REG_ROW_X_OFF: off_q[0] = data[31:0];
      wtsp_pkg::REG_ROW_Y_OFF: off_q[1] = data[31:0];
      wtsp_pkg::REG_ROW_W_OFF: off_q[2] = data[31:0];
      wtsp_pkg::REG_SCR_WIDTH: width_q = data[wtsp_pkg::SIZE_W-1:0];
      default:                 height_q = data[wtsp_pkg::SIZE_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [wtsp_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return 32'sh7fffffff - $urandom_range(0, 3);
      3: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  task automatic queue_point(logic [wtsp_pkg::POS_W-1:0] x, y, z);
    point_t p;
    p.px = x; p.py = y; p.pz = z;
    point_q.push_back(p);
  endtask

  // Wait until the pipeline has drained, then a little longer
  task automatic wait_idle();
    while (point_q.size() != 0 || pixel_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic random_setting(int mode);
    write_reg(wtsp_pkg::REG_ROW_X_LIN, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(wtsp_pkg::REG_ROW_Y_LIN, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(wtsp_pkg::REG_ROW_W_LIN, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(wtsp_pkg::REG_ROW_X_OFF, {16'd0, rand_pos()});
    write_reg(wtsp_pkg::REG_ROW_Y_OFF, {16'd0, rand_pos()});
    write_reg(wtsp_pkg::REG_ROW_W_OFF, {16'd0, (mode == 0) ? 32'sd0 : rand_pos()});
    case (mode)
      1: begin
        write_reg(wtsp_pkg::REG_SCR_WIDTH, 48'd8191);
        write_reg(wtsp_pkg::REG_SCR_HEIGHT, 48'd0);
      end
      2: begin
        write_reg(wtsp_pkg::REG_SCR_WIDTH, 48'd1);
        write_reg(wtsp_pkg::REG_SCR_HEIGHT, 48'd4096);
      end
      default: begin
        write_reg(wtsp_pkg::REG_SCR_WIDTH, wtsp_pkg::CFG_W'($urandom_range(1, 8191)));
        write_reg(wtsp_pkg::REG_SCR_HEIGHT, wtsp_pkg::CFG_W'($urandom_range(1, 8191)));
      end
    endcase
  endtask

  // Driver: bursts of beats with random gaps
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      point_q.pop_front();
    end
    if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      if (!(valid_i && stall_o)) valid_i <= 1'b0;
    end else if (!(valid_i && stall_o)) begin
      if (!send_pause && point_q.size() > ((valid_i && !stall_o) ? 0 : 0)
          && ($urandom_range(0, 9) != 0 || hold_off)) begin
        valid_i <= 1'b1;
        pos_x_i <= point_q[0].px;
        pos_y_i <= point_q[0].py;
        pos_z_i <= point_q[0].pz;
        pixel_q.push_back(project(point_q[0]));
        if ($urandom_range(0, 15) == 0) gap_cnt <= $urandom_range(1, 12);
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern and output check
  int stall_mode = 0;
  always @(posedge clk_i) begin
    pixel_t want;
    if (valid_o && !stall_i) begin
      n_beats++;
      if (pixel_q.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (want.fault) n_faults++;
        if (screen_x_o !== want.sx) begin
          $error("screen_x expected %0d got %0d", want.sx, screen_x_o);
          errors++;
        end
        if (screen_y_o !== want.sy) begin
          $error("screen_y expected %0d got %0d", want.sy, screen_y_o);
          errors++;
        end
        if (depth_w_o !== want.dw) begin
          $error("depth_w expected %0d got %0d", want.dw, depth_w_o);
          errors++;
        end
        if (div_fault_o !== want.fault) begin
          $error("div_fault expected %0b got %0b", want.fault, div_fault_o);
          errors++;
        end
      end
    end
    if (hold_off) stall_i <= 1'b1;
    else if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    else case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 3) == 0);
      default: stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Long hold-off on the output while the sender keeps offering
  initial begin
    int cnt;
    wait (n_beats > 400);
    hold_off = 1'b1;
    for (cnt = 0; cnt < 200; cnt++) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL world_to_screen_projection_top");
    $finish;
  end

  initial begin
    int m;
    lin_q[0] = '0; lin_q[1] = '0; lin_q[2] = '0;
    off_q[0] = '0; off_q[1] = '0; off_q[2] = 32'sd65536;
    width_q = 13'd1920; height_q = 13'd1080;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset matrix: fixed w of one, every point lands at the center
    queue_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    queue_point(0, 0, 0);
    wait_idle();

    // Identity-like view with z as w; extremes and zero w cases
    write_reg(wtsp_pkg::REG_ROW_X_LIN, {16'h0000, 16'h0000, 16'h1000});
    write_reg(wtsp_pkg::REG_ROW_Y_LIN, {16'h0000, 16'h1000, 16'h0000});
    write_reg(wtsp_pkg::REG_ROW_W_LIN, {16'h1000, 16'h0000, 16'h0000});
    write_reg(wtsp_pkg::REG_ROW_X_OFF, 48'd0);
    write_reg(wtsp_pkg::REG_ROW_Y_OFF, 48'd0);
    write_reg(wtsp_pkg::REG_ROW_W_OFF, 48'd0);
    write_reg(wtsp_pkg::REG_SCR_WIDTH, 48'd640);
    write_reg(wtsp_pkg::REG_SCR_HEIGHT, 48'd480);
    queue_point(32'sh10000, 32'sh10000, 0);
    queue_point(-32'sh10000, -32'sh10000, 0);
    queue_point(32'sh10000, -32'sh10000, 0);
    queue_point(-32'sh10000, 32'sh10000, 0);
    queue_point(32'sh8000, -32'sh4000, 32'sh10000);
    queue_point(32'sh8000, 32'sh4000, -32'sh10000);
    queue_point(32'sh7fffffff, 32'sh80000000, 1);
    queue_point(32'sh80000000, 32'sh7fffffff, -1);
    queue_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    queue_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    queue_point(5, 7, 3);
    queue_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    wait_idle();

    // Zero size: x collapses to zero, y to minus one
    write_reg(wtsp_pkg::REG_SCR_WIDTH, 48'd0);
    write_reg(wtsp_pkg::REG_SCR_HEIGHT, 48'd0);
    queue_point(32'sh1234, 32'sh5678, 32'sh10000);
    queue_point(32'sh1234, 32'sh5678, -32'sh10000);
    wait_idle();

    // Random phases under varied settings
    for (m = 0; m < 14; m++) begin
      int k;
      random_setting(m % 4);
      for (k = 0; k < 125; k++) begin
        if ($urandom_range(0, 9) == 0) queue_point(rand_pos(), rand_pos(), 0);
        else queue_point(rand_pos(), rand_pos(), rand_pos());
      end
      if (m == 5) begin
        // Sender pauses until the pipeline is empty
        while (point_q.size() > 60) @(posedge clk_i);
        send_pause = 1'b1;
        while (pixel_q.size() != 0 || valid_i) @(posedge clk_i);
        send_pause = 1'b0;
      end
      wait_idle();
    end

    $display("Checked %0d output beats, %0d with zero w, over 17 settings.",
             n_beats, n_faults);
    if (errors == 0) $display("PASS world_to_screen_projection_top");
    else $display("FAIL world_to_screen_projection_top");
    $finish;
  end

endmodule
